// ----- src/cartridge_bank_mapper_irq_top_defines.svh -----
// Assertion macros shared by the mapper modules.
// Included by the controller and datapath; depends on nothing else.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_TOP_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_TOP_DEFINES_SVH
// Assert an implication on every clock edge outside reset.
`define CBM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert an implication that also holds while reset is high.
`define CBM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/cbm_pkg.sv -----
// Package for the cartridge bank mapper: types, codes and sizes.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps
package cbm_pkg;
   localparam int WORK_RAM_DEPTH_DEF = 8192;
   localparam int PRG_BANK_BYTES     = 8192;
   localparam int CHR_BANK_BYTES     = 1024;
   localparam logic [21:0] PRG_MAX_BYTES = 22'd2097152;
   localparam logic [18:0] CHR_MAX_BYTES = 19'd262144;
   localparam logic [21:0] PRG_BYTES_RESET = 22'd262144;
   localparam logic [18:0] CHR_BYTES_RESET = 19'd8192;

   localparam logic [2:0] CMD_CPU_READ  = 3'd0;
   localparam logic [2:0] CMD_CPU_WRITE = 3'd1;
   localparam logic [2:0] CMD_PPU_READ  = 3'd2;
   localparam logic [2:0] CMD_PPU_WRITE = 3'd3;
   localparam logic [2:0] CMD_IRQ_TICK  = 3'd4;

   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_PRG  = 2'd1;
   localparam logic [1:0] TGT_RAM  = 2'd2;
   localparam logic [1:0] TGT_CHR  = 2'd3;

   localparam logic [1:0] CSR_PRG_BYTES = 2'd0;
   localparam logic [1:0] CSR_CHR_BYTES = 2'd1;
   localparam logic [1:0] CSR_CHR_RAM   = 2'd2;
   localparam logic [1:0] CSR_MIRROR    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_REDUCE,
      ST_RESULT
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic decode;
      logic reduce;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic reduce_done;
   } dp_status_type;
endpackage

// ----- src/cbm_ctrl.sv -----
// Controller state machine of the cartridge bank mapper.
// Depends on cbm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_top_defines.svh"
module cbm_ctrl
   import cbm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_start,
   output logic          req_busy,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);
   ctrl_state_type state_ff, state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // clear the work RAM after reset, then sequence each word: capture, decode, reduce banks, publish
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_busy = 1'b0;
            if (req_start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (status.reduce_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   `CBM_ASSERT(a_cap_idle, clock, reset, cmd.capture |-> state_ff == ST_IDLE, "capture outside idle")
   `CBM_ASSERT(a_fin_next, clock, reset, cmd.finish |=> !req_busy, "no idle after result")
   `CBM_ASSERT(a_cap_dec, clock, reset, cmd.capture |=> cmd.decode, "decode did not follow capture")
endmodule

// ----- src/cbm_datapath.sv -----
// Datapath of the cartridge bank mapper: mapper registers, IRQ counter,
// work RAM, bank reduction by repeated subtraction and the result word.
// Depends on cbm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cartridge_bank_mapper_irq_top_defines.svh"
module cbm_datapath
   import cbm_pkg::*;
#(
   parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [2:0]    req_command,
   input  logic [15:0]   req_bus_address,
   input  logic [7:0]    req_write_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [21:0]   csr_data,
   output logic          rsp_valid,
   output logic [1:0]    rsp_target,
   output logic [20:0]   rsp_mem_address,
   output logic [7:0]    rsp_read_data,
   output logic          rsp_mem_write,
   output logic          rsp_irq_active,
   output logic          rsp_mirror_horiz
);
   localparam int RA = $clog2(WORK_RAM_DEPTH);

   // configuration
   logic [21:0] prg_bytes_ff;
   logic [18:0] chr_bytes_ff;
   logic        chr_ram_ff;
   // mapper state
   logic [7:0]  bank_sel_ff;
   logic [7:0]  bank_ff [8];
   logic        mirror_ff, ram_en_ff, ram_prot_ff;
   logic [7:0]  irq_reload_val_ff, irq_count_ff;
   logic        irq_reload_ff, irq_en_ff, irq_flag_ff;
   // captured word
   logic [2:0]  cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   // reduction
   logic [7:0]  bank_rem_ff;
   logic [8:0]  count_ff;
   logic [8:0]  base_ff;
   logic        in_range_ff;
   // clearing
   logic [RA:0] clr_ff;
   // work RAM
   logic [7:0]  ram [WORK_RAM_DEPTH];
   logic [7:0]  ram_q_ff;

   logic [21:0] prg_eff;
   logic [18:0] chr_eff;
   logic [8:0]  prg_cnt, chr_cnt;
   logic        is_prg;
   logic [15:0] ram_off, ram_sub;
   logic [RA-1:0] ram_idx;

   always_comb begin
      prg_eff = (prg_bytes_ff > PRG_MAX_BYTES) ? PRG_MAX_BYTES : prg_bytes_ff;
      chr_eff = (chr_bytes_ff > CHR_MAX_BYTES) ? CHR_MAX_BYTES : chr_bytes_ff;
      prg_cnt = (prg_eff[21:13] == '0) ? 9'd1 : prg_eff[21:13];
      chr_cnt = (chr_eff[18:10] == '0) ? 9'd1 : chr_eff[18:10];
      is_prg  = (cmd_ff == CMD_CPU_READ);
      // fold the work RAM offset into the RAM depth
      ram_off = addr_ff - 16'h6000;
      ram_sub = '0;
      for (int k = 1; k < 8; k++) begin
         if ({3'b000, ram_off[12:0]} >= 16'(k * WORK_RAM_DEPTH))
            ram_sub = 16'(k * WORK_RAM_DEPTH);
      end
      ram_idx = RA'({3'b000, ram_off[12:0]} - ram_sub);
   end

   // clear the work RAM after reset, one byte a cycle
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step && !clr_ff[RA]) clr_ff <= clr_ff + 1'b1;
   end
   assign status.clear_done = (clr_ff == (RA+1)'(WORK_RAM_DEPTH - 1));

   // work RAM port: clear, write or read
   always_ff @(posedge clock) begin
      if (cmd.clear_step)
         ram[clr_ff[RA-1:0]] <= 8'h00;
      else if (cmd.decode && cmd_ff == CMD_CPU_WRITE && addr_ff >= 16'h6000
               && addr_ff < 16'h8000 && ram_en_ff && !ram_prot_ff)
         ram[ram_idx] <= data_ff;
      ram_q_ff <= ram[ram_idx];
   end

   // capture the input word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         addr_ff <= req_bus_address;
         data_ff <= req_write_data;
      end
   end

   // configuration and mapper registers
   logic [2:0] slot;
   logic [7:0] raw_bank;
   logic [1:0] pslot;
   always_comb begin
      slot = addr_ff[12:10] ^ {bank_sel_ff[7], 2'b00};
      unique case (slot)
         3'd0: raw_bank = bank_ff[0] & 8'hFE;
         3'd1: raw_bank = (bank_ff[0] & 8'hFE) + 8'd1;
         3'd2: raw_bank = bank_ff[1] & 8'hFE;
         3'd3: raw_bank = (bank_ff[1] & 8'hFE) + 8'd1;
         3'd4: raw_bank = bank_ff[2];
         3'd5: raw_bank = bank_ff[3];
         3'd6: raw_bank = bank_ff[4];
         default: raw_bank = bank_ff[5];
      endcase
      pslot = addr_ff[14:13];
      if (is_prg) begin
         unique case (pslot)
            2'd0: raw_bank = bank_ff[6];
            2'd1: raw_bank = bank_ff[7];
            2'd2: raw_bank = bank_ff[6];
            default: raw_bank = bank_ff[6];
         endcase
      end
   end
   // slots fixed to second-last or last bank skip the reduction
   logic fixed_slot;
   logic [8:0] fixed_bank;
   always_comb begin
      fixed_slot = 1'b0;
      fixed_bank = '0;
      if (is_prg) begin
         if (pslot == 2'd3) begin
            fixed_slot = 1'b1;
            fixed_bank = prg_cnt - 9'd1;
         end else if ((pslot == 2'd0 && bank_sel_ff[6]) ||
                      (pslot == 2'd2 && !bank_sel_ff[6])) begin
            fixed_slot = 1'b1;
            fixed_bank = (prg_cnt >= 9'd2) ? prg_cnt - 9'd2 : 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_bytes_ff      <= PRG_BYTES_RESET;
         chr_bytes_ff      <= CHR_BYTES_RESET;
         chr_ram_ff        <= 1'b1;
         bank_sel_ff       <= '0;
         for (int i = 0; i < 8; i++) bank_ff[i] <= '0;
         mirror_ff         <= 1'b0;
         ram_en_ff         <= 1'b0;
         ram_prot_ff       <= 1'b0;
         irq_reload_val_ff <= '0;
         irq_count_ff      <= '0;
         irq_reload_ff     <= 1'b0;
         irq_en_ff         <= 1'b0;
         irq_flag_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PRG_BYTES: prg_bytes_ff <= csr_data;
               CSR_CHR_BYTES: chr_bytes_ff <= csr_data[18:0];
               CSR_CHR_RAM:   chr_ram_ff   <= csr_data[0];
               default:       mirror_ff    <= csr_data[0];
            endcase
         end
         if (cmd.decode && cmd_ff == CMD_CPU_WRITE && addr_ff[15]) begin
            unique case (addr_ff[14:13])
               2'd0: if (addr_ff[0]) bank_ff[bank_sel_ff[2:0]] <= data_ff;
                     else bank_sel_ff <= data_ff;
               2'd1: if (addr_ff[0]) begin
                        ram_en_ff   <= data_ff[7];
                        ram_prot_ff <= data_ff[6];
                     end else mirror_ff <= data_ff[0];
               2'd2: if (addr_ff[0]) irq_reload_ff <= 1'b1;
                     else irq_reload_val_ff <= data_ff;
               default: if (addr_ff[0]) irq_en_ff <= 1'b1;
                        else begin
                           irq_en_ff   <= 1'b0;
                           irq_flag_ff <= 1'b0;
                        end
            endcase
         end
         // run the scanline counter
         if (cmd.decode && cmd_ff == CMD_IRQ_TICK) begin
            if (irq_reload_ff) begin
               irq_count_ff  <= irq_reload_val_ff;
               irq_reload_ff <= 1'b0;
            end else if (irq_count_ff == 8'd0) begin
               irq_count_ff <= irq_reload_val_ff;
               if (irq_en_ff) irq_flag_ff <= 1'b1;
            end else begin
               irq_count_ff <= irq_count_ff - 8'd1;
            end
         end
      end
   end

   // reduce the bank number modulo the count by subtraction steps
   logic [8:0] rem9;
   assign rem9 = {1'b0, bank_rem_ff};
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         bank_rem_ff <= raw_bank;
         count_ff    <= is_prg ? prg_cnt : chr_cnt;
         base_ff     <= fixed_bank;
         in_range_ff <= fixed_slot;
      end else if (cmd.reduce && !in_range_ff) begin
         if (rem9 >= count_ff) bank_rem_ff <= 8'(rem9 - count_ff);
         else begin
            base_ff     <= rem9;
            in_range_ff <= 1'b1;
         end
      end
   end
   assign status.reduce_done = in_range_ff;

   // form the result word
   logic [21:0] prg_idx;
   logic [18:0] chr_idx;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cmd.finish;
   end
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_target      <= TGT_NONE;
         rsp_mem_address <= '0;
         rsp_read_data   <= '0;
         rsp_mem_write   <= 1'b0;
         unique case (cmd_ff)
            CMD_CPU_READ: begin
               if (addr_ff[15]) begin
                  if (prg_idx < prg_eff) begin
                     rsp_target      <= TGT_PRG;
                     rsp_mem_address <= prg_idx[20:0];
                  end
               end else if (addr_ff >= 16'h6000 && ram_en_ff) begin
                  rsp_target    <= TGT_RAM;
                  rsp_read_data <= ram_q_ff;
               end
            end
            CMD_PPU_READ, CMD_PPU_WRITE: begin
               if (chr_idx < chr_eff &&
                   (cmd_ff == CMD_PPU_READ || chr_ram_ff)) begin
                  rsp_target      <= TGT_CHR;
                  rsp_mem_address <= {2'b00, chr_idx};
                  rsp_mem_write   <= (cmd_ff == CMD_PPU_WRITE);
               end
            end
            default: ;
         endcase
      end
   end
   assign prg_idx = {base_ff[8:0], addr_ff[12:0]};
   assign chr_idx = {base_ff[8:0], addr_ff[9:0]};
   assign rsp_irq_active   = irq_flag_ff;
   assign rsp_mirror_horiz = mirror_ff;

   `CBM_ASSERT(a_rem_bound, clock, reset, (cmd.finish && !fixed_slot) |-> base_ff < count_ff, "bank not reduced")
   `CBM_ASSERT(a_wr_tgt, clock, reset, (rsp_valid && rsp_mem_write) |-> rsp_target == TGT_CHR, "write without pattern target")
   `CBM_ASSERT(a_valid_one, clock, reset, rsp_valid |=> !rsp_valid, "result held two cycles")
endmodule

// ----- src/cartridge_bank_mapper_irq_top.sv -----
// Cartridge bank mapper with scanline IRQ counter: top level.
// Instantiates cbm_ctrl and cbm_datapath; depends on cbm_pkg.
//
// Usage: present command, bus_address and write_data with start while
// busy is low; the word is taken on that edge. Its result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high. The receiver cannot
// stall, so nothing waits on the output side.
// Steps: after the start edge the word passes the decode, reduce and result
// states; rsp_valid is registered from the result state. Reduce subtracts
// the bank count until the bank is below it; a fixed program slot bank needs
// no subtraction. Every command runs the bank reduction, writes and ticks
// included. One word is in flight at a time; busy is low while rsp_valid is
// high, so the next word can be taken at the edge that ends it.
// Configuration: csr_valid/csr_ready write register csr_index; csr_ready is
// always high; write only while idle.
// Reset: synchronous, active high. After reset the work RAM is cleared one
// byte per cycle, with busy high.
`timescale 1ns / 1ps
module cartridge_bank_mapper_irq_top
   import cbm_pkg::*;
#(
   parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_target,
   output logic [20:0] rsp_mem_address,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_mem_write,
   output logic        rsp_irq_active,
   output logic        rsp_mirror_horiz
);
   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   cbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_start(start), .req_busy(busy),
      .status(status), .cmd(cmd)
   );

   cbm_datapath #(.WORK_RAM_DEPTH(WORK_RAM_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_command(req_command), .req_bus_address(req_bus_address),
      .req_write_data(req_write_data),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_target(rsp_target),
      .rsp_mem_address(rsp_mem_address), .rsp_read_data(rsp_read_data),
      .rsp_mem_write(rsp_mem_write), .rsp_irq_active(rsp_irq_active),
      .rsp_mirror_horiz(rsp_mirror_horiz)
   );
endmodule
